// ===== hw/rtl/txc_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Grid geometry, field widths, character and operation codes, and the
// controller state and command types that the modules share.
// ----------------------------------------------------------------------------
package txc_pkg;

  // Grid geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_COUNT = CELL_COUNT - COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);

  // Field widths of the channels.
  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 11;
  localparam int CELL_W  = 16;
  localparam int POS_W   = 11;
  localparam int COLOR_W = 8;

  // Width used to compare a cell index against the cell count.
  localparam int CMP_W = 16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Character codes.
  localparam logic [CHAR_W-1:0] NEWLINE_CODE   = 8'd10;
  localparam logic [CHAR_W-1:0] BACKSPACE_CODE = 8'd8;
  localparam logic [CHAR_W-1:0] SPACE_CODE     = 8'd32;

  // Attribute after reset.
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd15;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_COPY,
    ST_BLANK,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_PUT,
    CMD_CLEAR_LOAD,
    CMD_READ_LATCH,
    CMD_COPY,
    CMD_BOTTOM_LOAD,
    CMD_SWEEP,
    CMD_INIT_SWEEP,
    CMD_RESULT
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            need_scroll;
    logic            copy_done;
    logic            sweep_last;
    logic            out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/txc_in_if.sv =====
// ----------------------------------------------------------------------------
// Text console input channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
interface txc_in_if
  import txc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, output operation, output char_code,
                  output cell_index, input ready);
  modport sink   (input valid, input operation, input char_code,
                  input cell_index, output ready);
endinterface

// ===== hw/rtl/txc_out_if.sv =====
// ----------------------------------------------------------------------------
// Text console result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface txc_out_if
  import txc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  logic [POS_W-1:0]  cursor_position;
  logic              scrolled;

  modport source (output valid, output cell_value, output cursor_position,
                  output scrolled, input ready);
  modport sink   (input valid, input cell_value, input cursor_position,
                  input scrolled, output ready);
endinterface

// ===== hw/rtl/txc_datapath.sv =====
// ----------------------------------------------------------------------------
// Text console datapath
// Screen memory, cursor, sweep and copy counters, colour register and the
// result register, all stepped by commands from the controller.
// ----------------------------------------------------------------------------
module txc_datapath
  import txc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [IDX_W-1:0]  in_cell_index,
  input  logic              cfg_we,
  input  logic [COLOR_W-1:0] cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CELL_W-1:0] out_cell_value,
  output logic [POS_W-1:0]  out_cursor_position,
  output logic              out_scrolled
);

  // Screen memory with one write port and one registered read port.
  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [CELL_W-1:0] mem_wd;
  logic [ADDR_W-1:0] mem_ra;
  logic [CELL_W-1:0] rd_data_r;

  // Captured word.
  logic [OP_W-1:0]   op_r;
  logic [CHAR_W-1:0] ch_r;
  logic [IDX_W-1:0]  idx_r;

  // Control state.
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ADDR_W-1:0]  sweep_r, sweep_nxt;
  logic [ADDR_W-1:0]  copy_r, copy_nxt;
  logic               pend_r, pend_nxt;
  logic [ADDR_W-1:0]  pend_addr_r;
  logic [COLOR_W-1:0] color_r;
  logic               out_valid_r, out_valid_nxt;

  // Result payload.
  logic [CELL_W-1:0] value_r;
  logic              scroll_r;
  logic [CELL_W-1:0] out_value_r;
  logic [POS_W-1:0]  out_pos_r;
  logic              out_scroll_r;

  logic [ADDR_W-1:0] cur_addr;
  logic              last_col;
  logic              last_row;
  logic              copy_end;
  logic              idx_ok;

  assign cur_addr = ADDR_W'(ADDR_W'(row_r) * ADDR_W'(COLUMNS)) + ADDR_W'(col_r);
  assign last_col = (col_r == COL_W'(COLUMNS - 1));
  assign last_row = (row_r == ROW_W'(ROWS - 1));
  assign copy_end = (copy_r == ADDR_W'(COPY_COUNT));
  assign idx_ok   = (CMP_W'(idx_r) < CMP_W'(CELL_COUNT));

  // Status towards the controller.
  always_comb begin
    status.op          = op_r;
    status.need_scroll = last_row && (op_r == OP_PUT) &&
                         ((ch_r == NEWLINE_CODE) ||
                          ((ch_r != BACKSPACE_CODE) && last_col));
    status.copy_done   = copy_end && !pend_r;
    status.sweep_last  = (sweep_r == ADDR_W'(CELL_COUNT - 1));
    status.out_free    = !out_valid_r || out_ready;
  end

  // Memory ports and next values of the cursor and counters.
  always_comb begin
    mem_we        = 1'b0;
    mem_wa        = cur_addr;
    mem_wd        = {color_r, ch_r};
    mem_ra        = ADDR_W'(idx_r);
    row_nxt       = row_r;
    col_nxt       = col_r;
    sweep_nxt     = sweep_r;
    copy_nxt      = copy_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // A copied cell is written in the cycle after its read.
    if (pend_r) begin
      mem_we = 1'b1;
      mem_wa = pend_addr_r;
      mem_wd = rd_data_r;
    end

    unique case (cmd)
      CMD_PUT: begin
        copy_nxt = '0;
        pend_nxt = 1'b0;
        if (ch_r == NEWLINE_CODE) begin
          col_nxt = '0;
          if (!last_row) begin
            row_nxt = ROW_W'(row_r + 1'b1);
          end
        end else if (ch_r == BACKSPACE_CODE) begin
          if (col_r != '0) begin
            mem_we  = 1'b1;
            mem_wa  = ADDR_W'(cur_addr - 1'b1);
            mem_wd  = {color_r, SPACE_CODE};
            col_nxt = COL_W'(col_r - 1'b1);
          end
        end else begin
          mem_we = 1'b1;
          if (last_col) begin
            col_nxt = '0;
            if (!last_row) begin
              row_nxt = ROW_W'(row_r + 1'b1);
            end
          end else begin
            col_nxt = COL_W'(col_r + 1'b1);
          end
        end
      end
      CMD_CLEAR_LOAD: begin
        sweep_nxt = '0;
        row_nxt   = '0;
        col_nxt   = '0;
      end
      CMD_COPY: begin
        mem_ra = ADDR_W'(copy_r + ADDR_W'(COLUMNS));
        if (!copy_end) begin
          copy_nxt = ADDR_W'(copy_r + 1'b1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      CMD_BOTTOM_LOAD: begin
        sweep_nxt = ADDR_W'(COPY_COUNT);
      end
      CMD_SWEEP: begin
        mem_we    = 1'b1;
        mem_wa    = sweep_r;
        mem_wd    = {color_r, SPACE_CODE};
        sweep_nxt = ADDR_W'(sweep_r + 1'b1);
      end
      CMD_INIT_SWEEP: begin
        mem_we    = 1'b1;
        mem_wa    = sweep_r;
        mem_wd    = {RESET_COLOR, SPACE_CODE};
        sweep_nxt = ADDR_W'(sweep_r + 1'b1);
      end
      CMD_RESULT: begin
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Screen memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      sweep_r     <= '0;
      copy_r      <= '0;
      pend_r      <= 1'b0;
      color_r     <= RESET_COLOR;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      sweep_r     <= sweep_nxt;
      copy_r      <= copy_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        color_r <= cfg_data;
      end
    end
  end

  // Captured word, result fields and output register.
  always_ff @(posedge clk) begin
    if (cmd == CMD_COPY) begin
      pend_addr_r <= copy_r;
    end
    unique case (cmd)
      CMD_CAPTURE: begin
        op_r     <= in_operation;
        ch_r     <= in_char_code;
        idx_r    <= in_cell_index;
        value_r  <= '0;
        scroll_r <= 1'b0;
      end
      CMD_PUT: begin
        scroll_r <= status.need_scroll;
      end
      CMD_READ_LATCH: begin
        value_r <= idx_ok ? rd_data_r : '0;
      end
      CMD_RESULT: begin
        out_value_r  <= value_r;
        out_pos_r    <= POS_W'(cur_addr);
        out_scroll_r <= scroll_r;
      end
      default: begin
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_cell_value      = out_value_r;
  assign out_cursor_position = out_pos_r;
  assign out_scrolled        = out_scroll_r;

endmodule

// ===== hw/rtl/txc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text console controller
// Sequences reset blanking, put, clear, read and scroll through commands
// to the datapath.
// ----------------------------------------------------------------------------
module txc_ctrl
  import txc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd = CMD_INIT_SWEEP;
        if (status.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd       = CMD_CAPTURE;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (status.op == OP_PUT) begin
          cmd       = CMD_PUT;
          state_nxt = status.need_scroll ? ST_COPY : ST_DONE;
        end else if (status.op == OP_CLEAR) begin
          cmd       = CMD_CLEAR_LOAD;
          state_nxt = ST_BLANK;
        end else if (status.op == OP_READ) begin
          // The read address is the captured index; data arrives next cycle.
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        cmd       = CMD_READ_LATCH;
        state_nxt = ST_DONE;
      end
      ST_COPY: begin
        if (status.copy_done) begin
          cmd       = CMD_BOTTOM_LOAD;
          state_nxt = ST_BLANK;
        end else begin
          cmd = CMD_COPY;
        end
      end
      ST_BLANK: begin
        cmd = CMD_SWEEP;
        if (status.sweep_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd       = CMD_RESULT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/text_console_writer_top.sv =====
// ----------------------------------------------------------------------------
// Text console writer
// 80 by 25 text grid with cursor, wrap, scroll, clear and cell read-back.
// ----------------------------------------------------------------------------
// Usage: each word on in_ch is one operation (put character, clear, read
// cell); each produces exactly one word on out_ch with the cell value, the
// cursor position afterwards and a scroll flag. cfg_data written with
// cfg_valid/cfg_ready sets the attribute used for new and blanked cells.
// Operations run one at a time, paced by the controller and by the screen
// memory, which takes one read and one write a cycle. A put is captured,
// decoded and then registered as a result; a read adds a state that latches
// the cell read from memory. A put that scrolls copies 1920 cells at one
// per cycle and blanks 80; a clear blanks 2000 cells. After reset a
// clearing pass fills the screen with spaces in the reset colour; in_ch is
// not ready until it ends, while configuration writes are taken at once. A
// result waits in the output register while out_ch stalls, and the next
// word is still accepted; it completes but its own result waits until the
// register is free.
// ----------------------------------------------------------------------------
module text_console_writer_top
  import txc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  txc_in_if.sink             in_ch,
  txc_out_if.source          out_ch,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COLOR_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  // The colour register takes a write in any cycle.
  assign cfg_ready   = 1'b1;
  assign in_ch.ready = in_ready;

  // Controller.
  txc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  txc_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_operation        (in_ch.operation),
    .in_char_code        (in_ch.char_code),
    .in_cell_index       (in_ch.cell_index),
    .cfg_we              (cfg_valid),
    .cfg_data            (cfg_data),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_cell_value      (out_ch.cell_value),
    .out_cursor_position (out_ch.cursor_position),
    .out_scrolled        (out_ch.scrolled)
  );

endmodule
